// ===== sv/tae_pkg.sv =====
package tae_pkg;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_EDGE_A = 2'd1;
  localparam logic [1:0] REQ_EDGE_B = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GYRO_STEP_GAIN = 2'd0;
  localparam logic [1:0] CFG_ENCODER_GAIN   = 2'd1;
  localparam logic [1:0] CFG_RATE_DEADBAND  = 2'd2;

  localparam logic [15:0] GYRO_STEP_GAIN_RST = 16'd3202;
  localparam logic [19:0] ENCODER_GAIN_RST   = 20'd11796;
  localparam logic [15:0] RATE_DEADBAND_RST  = 16'd131;

  localparam logic signed [15:0] ONE_G = 16'sd16384;
  localparam int QUARTER_TURN = 23040;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_EST  = 3'b010,
    DIV_FIX  = 3'b100
  } div_state_t;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [15:0] accel;
    logic signed [15:0] gyro;
    logic               other;
  } in_item_t;

  typedef struct packed {
    logic               neg;
    logic               integ;
    logic signed [17:0] tsum;
    logic signed [16:0] rate;
    logic signed [31:0] ecount;
  } s1_t;

  typedef struct packed {
    logic signed [34:0] gprod;
    logic [31:0]        eang;
    logic signed [15:0] tilt;
    logic signed [15:0] offset;
    logic signed [16:0] rate;
  } s2_t;

endpackage

// ===== sv/tilt_angle_estimator.sv =====
// Tilt estimator: accelerometer arcsine tilt, trapezoidal gyro integration and
// a quadrature encoder count.
//
// in_*  : requests. in_tuser is the request kind (sensor sample, edge on channel
//         A, edge on channel B). Encoder edges and the first CALIB_SAMPLES
//         sensor samples give no result; every later sample gives one.
// out_* : results, one per post-calibration sensor sample, in request order.
// cfg_* : register writes (step gain, encoder gain, rate deadband), to be made only
//         while the block is idle (the block does not enforce it); cfg_ready is always high.
//
// Throughput is one request per cycle, unless the offset divide or a full pipeline
// holds the input, through a three-stage pipeline (rate path, arcsine ROM read,
// gains and angle sums) ahead of the output register. After the last calibration
// sample the input holds off while the gyro offset divide (reciprocal multiply
// plus one correction) finishes.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// calibration, angle and count state. When out_tready is low the result stays
// in the output register and the pipeline keeps filling its empty stages, then
// in_tready drops once every stage is full and a sensor sample waits at the input.
module tilt_angle_estimator #(
  parameter int CALIB_SAMPLES = 10,
  parameter int ASIN_ENTRIES  = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // accel_y_raw, gyro_x_raw, other_channel_level
  input  logic [1:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // encoder_angle, accel_angle, gyro_angle, gyro_rate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int CW = $clog2(CALIB_SAMPLES + 1);
  localparam int IW = $clog2(ASIN_ENTRIES + 1);
  localparam int PW = IW + 15;
  localparam int DIV_SH = 24;
  localparam logic [DIV_SH:0] DIV_RECIP = (DIV_SH + 1)'((64'd1 << DIV_SH) / CALIB_SAMPLES);

  typedef logic [ASIN_ENTRIES:0][14:0] asin_rom_t;

  function automatic logic [63:0] sine_step(logic [63:0] term, logic [63:0] x);
    return (((term * x) >> 30) * x) >> 30;
  endfunction

  // sine of h/512 degree in Q30, Taylor series through x^13
  function automatic logic [63:0] sine_q30(logic [63:0] h);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    x = (h * tae_pkg::PI_Q30 + 64'd46080) / 64'd92160;
    t = x;
    s = signed'(x);
    t = sine_step(t, x) / 64'd6;
    s = s - signed'(t);
    t = sine_step(t, x) / 64'd20;
    s = s + signed'(t);
    t = sine_step(t, x) / 64'd42;
    s = s - signed'(t);
    t = sine_step(t, x) / 64'd72;
    s = s + signed'(t);
    t = sine_step(t, x) / 64'd110;
    s = s - signed'(t);
    t = sine_step(t, x) / 64'd156;
    s = s + signed'(t);
    return (s < 0) ? 64'd0 : unsigned'(s);
  endfunction

  function automatic asin_rom_t build_rom();
    asin_rom_t   rom;
    logic [63:0] lim;
    int          lo;
    int          hi;
    int          mid;
    for (int i = 0; i <= ASIN_ENTRIES; i++) begin
      lo  = 0;
      hi  = tae_pkg::QUARTER_TURN;
      lim = 64'(i) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (sine_q30(64'(2 * mid - 1)) * 64'(ASIN_ENTRIES) <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      rom[i] = (i == ASIN_ENTRIES) ? 15'(tae_pkg::QUARTER_TURN) : 15'(lo);
    end
    return rom;
  endfunction

  localparam asin_rom_t ASIN_ROM = build_rom();

  // configuration
  logic [15:0] gyro_step_gain_r;
  logic [19:0] encoder_gain_r;
  logic [15:0] rate_deadband_r;

  // state
  logic [CW-1:0]       calib_count_r;
  logic signed [20:0]  gyro_sum_r;
  logic signed [15:0]  gyro_offset_r;
  logic signed [16:0]  prev_rate_r;
  logic [47:0]         gyro_accum_r;   // lower 16 bits never reach an output
  logic signed [15:0]  angle_offset_r;
  logic signed [31:0]  encoder_count_r;

  tae_pkg::div_state_t div_state_r;
  logic [20:0]         div_mag_r;
  logic                div_neg_r;
  logic [20:0]         div_q_r;

  // pipeline
  tae_pkg::in_item_t in_r;
  logic              v0_r;
  tae_pkg::s1_t      s1_r;
  logic [14:0]       rom_q_r;
  logic              v1_r;
  tae_pkg::s2_t      s2_r;
  logic              v2_r;
  logic [96:0]       out_data_r;
  logic              out_v_r;

  logic fire0, fire1, fire2, rdy1, rdy2, rdy3, load1;
  logic is_sample, calib_done;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !v0_r || fire0;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_data_r};

  assign rdy3  = !out_v_r || out_tready;
  assign fire2 = v2_r && rdy3;
  assign rdy2  = !v2_r || fire2;
  assign fire1 = v1_r && rdy2;
  assign rdy1  = !v1_r || fire1;

  assign is_sample  = (in_r.req == tae_pkg::REQ_SAMPLE);
  assign calib_done = (calib_count_r == CW'(CALIB_SAMPLES));
  assign fire0 = v0_r && (div_state_r == tae_pkg::DIV_IDLE) &&
                 (!(is_sample && calib_done) || rdy1);
  assign load1 = fire0 && is_sample && calib_done;

  // ---------------- stage 1: rate path, encoder, calibration, ROM index
  logic               enc_up;
  logic signed [31:0] enc_count_nxt;
  logic signed [20:0] gyro_sum_nxt;
  logic [CW-1:0]      calib_count_nxt;
  logic signed [16:0] rate;
  logic signed [17:0] rate_diff;
  logic [17:0]        rate_diff_abs;
  logic               rate_hold;
  logic signed [16:0] rate_sel;
  logic signed [15:0] accel_c;
  logic [15:0]        accel_mag;
  logic [PW-1:0]      idx_prod;
  logic [IW-1:0]      rom_idx;

  always_comb begin
    enc_up = (in_r.req == tae_pkg::REQ_EDGE_A) ? !in_r.other : in_r.other;
    enc_count_nxt = enc_up ? encoder_count_r + 32'sd1 : encoder_count_r - 32'sd1;

    gyro_sum_nxt    = gyro_sum_r + 21'(in_r.gyro);
    calib_count_nxt = calib_count_r + CW'(1);

    rate          = 17'(in_r.gyro) - 17'(gyro_offset_r);
    rate_diff     = 18'(rate) - 18'(prev_rate_r);
    rate_diff_abs = rate_diff[17] ? 18'(-rate_diff) : 18'(rate_diff);
    rate_hold     = rate_diff_abs < {2'b00, rate_deadband_r};
    rate_sel      = rate_hold ? prev_rate_r : rate;

    if (in_r.accel > tae_pkg::ONE_G) begin
      accel_c = tae_pkg::ONE_G;
    end else if (in_r.accel < -tae_pkg::ONE_G) begin
      accel_c = -tae_pkg::ONE_G;
    end else begin
      accel_c = in_r.accel;
    end
    accel_mag = accel_c[15] ? 16'(-accel_c) : 16'(accel_c);
    idx_prod  = PW'(accel_mag[14:0]) * PW'(ASIN_ENTRIES) + PW'(8192);
    rom_idx   = idx_prod[14 +: IW];
  end

  // ---------------- stage 2: sign, angle offset latch, gain products
  logic signed [15:0] tilt;
  logic signed [15:0] offset_eff;
  logic signed [34:0] gprod;
  logic signed [52:0] eprod;

  always_comb begin
    tilt       = s1_r.neg ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
    offset_eff = (angle_offset_r == 16'sd0) ? tilt : angle_offset_r;
    gprod      = s1_r.tsum * $signed({1'b0, gyro_step_gain_r});
    eprod      = s1_r.ecount * $signed({1'b0, encoder_gain_r});
  end

  // ---------------- stage 3: accumulate and add offsets
  logic [47:0] accum_nxt;
  logic [31:0] gyro_angle;
  logic [31:0] encoder_angle;

  always_comb begin
    accum_nxt     = gyro_accum_r + 48'(s2_r.gprod);
    gyro_angle    = accum_nxt[47:16] + 32'(s2_r.offset);
    encoder_angle = s2_r.eang + 32'(s2_r.offset);
  end

  // ---------------- offset divide: q = sum / CALIB_SAMPLES, toward zero
  logic [20:0]        sum_mag;
  logic [45:0]        recip_prod;
  logic [20:0]        q_mul;
  logic [20:0]        q_rem;
  logic [20:0]        q_fix;

  always_comb begin
    sum_mag    = gyro_sum_r[20] ? 21'(-gyro_sum_r) : 21'(gyro_sum_r);
    recip_prod = 46'(sum_mag) * 46'(DIV_RECIP);
    q_mul      = 21'(div_q_r * 21'(CALIB_SAMPLES));
    q_rem      = div_mag_r - q_mul;
    q_fix      = (q_rem >= 21'(CALIB_SAMPLES)) ? div_q_r + 21'd1 : div_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_step_gain_r <= tae_pkg::GYRO_STEP_GAIN_RST;
      encoder_gain_r   <= tae_pkg::ENCODER_GAIN_RST;
      rate_deadband_r  <= tae_pkg::RATE_DEADBAND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tae_pkg::CFG_GYRO_STEP_GAIN: gyro_step_gain_r <= cfg_data[15:0];
        tae_pkg::CFG_ENCODER_GAIN:   encoder_gain_r   <= cfg_data;
        tae_pkg::CFG_RATE_DEADBAND:  rate_deadband_r  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r            <= 1'b0;
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      out_v_r         <= 1'b0;
      calib_count_r   <= '0;
      gyro_sum_r      <= '0;
      gyro_offset_r   <= '0;
      prev_rate_r     <= '0;
      gyro_accum_r    <= '0;
      angle_offset_r  <= '0;
      encoder_count_r <= '0;
      div_state_r     <= tae_pkg::DIV_IDLE;
    end else begin
      if (in_tvalid && in_tready) begin
        v0_r <= 1'b1;
      end else if (fire0) begin
        v0_r <= 1'b0;
      end

      if (fire0) begin
        unique case (in_r.req)
          tae_pkg::REQ_EDGE_A, tae_pkg::REQ_EDGE_B: begin
            encoder_count_r <= enc_count_nxt;
          end
          tae_pkg::REQ_SAMPLE: begin
            if (!calib_done) begin
              gyro_sum_r    <= gyro_sum_nxt;
              calib_count_r <= calib_count_nxt;
              if (calib_count_nxt == CW'(CALIB_SAMPLES)) begin
                div_state_r <= tae_pkg::DIV_EST;
              end
            end else begin
              prev_rate_r <= rate_sel;
            end
          end
          default: begin
          end
        endcase
      end

      unique case (div_state_r)
        tae_pkg::DIV_EST:  div_state_r <= tae_pkg::DIV_FIX;
        tae_pkg::DIV_FIX: begin
          gyro_offset_r <= div_neg_r ? 16'(-q_fix) : 16'(q_fix);
          div_state_r   <= tae_pkg::DIV_IDLE;
        end
        default: begin
        end
      endcase

      if (load1) begin
        v1_r <= 1'b1;
      end else if (fire1) begin
        v1_r <= 1'b0;
      end

      if (fire1) begin
        v2_r           <= 1'b1;
        angle_offset_r <= offset_eff;
      end else if (fire2) begin
        v2_r <= 1'b0;
      end

      if (fire2) begin
        out_v_r      <= 1'b1;
        gyro_accum_r <= accum_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.req   <= in_tuser;
      in_r.accel <= in_tdata[15:0];
      in_r.gyro  <= in_tdata[31:16];
      in_r.other <= in_tdata[32];
    end
    if (div_state_r == tae_pkg::DIV_EST) begin
      div_mag_r <= sum_mag;
      div_neg_r <= gyro_sum_r[20];
      div_q_r   <= recip_prod[DIV_SH +: 21];
    end
    if (load1) begin
      rom_q_r     <= ASIN_ROM[rom_idx];
      s1_r.neg    <= accel_c[15];
      s1_r.integ  <= !rate_hold;
      s1_r.tsum   <= 18'(prev_rate_r) + 18'(rate);
      s1_r.rate   <= rate_sel;
      s1_r.ecount <= encoder_count_r;
    end
    if (fire1) begin
      s2_r.gprod  <= s1_r.integ ? gprod : 35'sd0;
      s2_r.eang   <= eprod[39:8];
      s2_r.tilt   <= tilt;
      s2_r.offset <= offset_eff;
      s2_r.rate   <= s1_r.rate;
    end
    if (fire2) begin
      out_data_r <= {s2_r.rate, gyro_angle, s2_r.tilt, encoder_angle};
    end
  end

  // no result may enter the pipeline before the gyro offset is known
  a_result_after_calib: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> calib_done && (div_state_r == tae_pkg::DIV_IDLE))
    else $error("result in flight before calibration finished");

  // the divide only runs once the calibration count is full
  a_div_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    (div_state_r != tae_pkg::DIV_IDLE) |-> calib_done)
    else $error("offset divide started early");

  // once latched, the angle offset never changes
  a_offset_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (angle_offset_r != 16'sd0) |=> (angle_offset_r == $past(angle_offset_r)))
    else $error("angle offset changed after latch");

  // a request waiting in the input register is neither lost nor altered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !fire0) |=> (v0_r && $stable(in_r)))
    else $error("pending request dropped");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CALIB_SAMPLES = 10;
  localparam int ASIN_ENTRIES  = 1024;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef struct {
    logic signed [31:0] encoder_angle;
    logic signed [15:0] accel_angle;
    logic signed [31:0] gyro_angle;
    logic signed [16:0] gyro_rate;
  } tilt_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // accel_y_raw, gyro_x_raw, other_channel_level
  logic [1:0]   in_tuser = '0;   // req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // encoder_angle, accel_angle, gyro_angle, gyro_rate
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [19:0]  cfg_data = '0;

  tilt_angle_estimator #(
    .CALIB_SAMPLES(CALIB_SAMPLES),
    .ASIN_ENTRIES (ASIN_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0]        asin_table [0:ASIN_ENTRIES];
  logic [15:0]        gyro_step_gain = tae_pkg::GYRO_STEP_GAIN_RST;
  logic [19:0]        encoder_gain   = tae_pkg::ENCODER_GAIN_RST;
  logic [15:0]        rate_deadband  = tae_pkg::RATE_DEADBAND_RST;
  int                 calib_count    = 0;
  logic signed [20:0] gyro_sum       = '0;
  logic signed [15:0] gyro_offset    = '0;
  int                 prev_rate      = 0;
  logic [63:0]        gyro_accum     = '0;
  logic signed [15:0] angle_offset   = '0;
  logic signed [31:0] encoder_count  = '0;

  tae_pkg::in_item_t req_queue [$];
  tilt_result_t      expected_angles [$];
  tae_pkg::in_item_t on_bus;
  tilt_result_t      want;
  int           reqs_queued   = 0;
  int           reqs_accepted = 0;
  int           results_seen  = 0;
  int           fail_count    = 0;
  int           send_idle_pct = 9;
  int           recv_idle_pct = 57;
  int           hold_left     = 0;
  int           next_hold_at  = 120;
  logic signed [15:0] gyro_walk = '0;

  // sine of h/512 degree in Q30, Taylor series through x^13
  function automatic longint unsigned sine_q30(input longint unsigned h);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x = (h * tae_pkg::PI_Q30 + 64'd46080) / 64'd92160;
    term = x;
    sum = x;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  task automatic predict_request(input tae_pkg::in_item_t r);
    int           accel;
    int           mag;
    int           idx;
    int           tilt;
    int           rate;
    int           diff;
    longint       eprod;
    tilt_result_t res;
    case (r.req)
      tae_pkg::REQ_EDGE_A: begin
        if (r.other) encoder_count = encoder_count - 1;
        else encoder_count = encoder_count + 1;
      end
      tae_pkg::REQ_EDGE_B: begin
        if (r.other) encoder_count = encoder_count + 1;
        else encoder_count = encoder_count - 1;
      end
      tae_pkg::REQ_SAMPLE: begin
        if (calib_count < CALIB_SAMPLES) begin
          gyro_sum = gyro_sum + r.gyro;
          calib_count++;
          if (calib_count == CALIB_SAMPLES) gyro_offset = 16'(gyro_sum / CALIB_SAMPLES);
        end else begin
          accel = int'(r.accel);
          if (accel > tae_pkg::ONE_G) accel = tae_pkg::ONE_G;
          if (accel < -tae_pkg::ONE_G) accel = -tae_pkg::ONE_G;
          mag = (accel < 0) ? -accel : accel;
          idx = (mag * ASIN_ENTRIES + 8192) >> 14;
          if (idx > ASIN_ENTRIES) idx = ASIN_ENTRIES;
          tilt = int'(asin_table[idx]);
          if (accel < 0) tilt = -tilt;
          // zero tilt leaves the offset open for the next sample
          if (angle_offset == 0) angle_offset = 16'(tilt);

          rate = int'(r.gyro) - int'(gyro_offset);
          diff = rate - prev_rate;
          if (diff < 0) diff = -diff;
          if (diff < int'(rate_deadband)) begin
            rate = prev_rate;
          end else begin
            gyro_accum = gyro_accum + longint'(prev_rate + rate) * longint'(gyro_step_gain);
          end
          prev_rate = rate;

          eprod = longint'(encoder_count) * longint'(encoder_gain);
          res.encoder_angle = eprod[39:8] + int'(angle_offset);
          res.accel_angle   = tilt[15:0];
          res.gyro_angle    = gyro_accum[47:16] + int'(angle_offset);
          res.gyro_rate     = rate[16:0];
          expected_angles.push_back(res);
        end
      end
      default: ;  // reserved request kind is dropped
    endcase
  endtask

  task automatic add_request(input logic [1:0] kind, input logic signed [15:0] accel,
                             input logic signed [15:0] gyro, input logic other);
    tae_pkg::in_item_t r;
    r.req = kind;
    r.accel = accel;
    r.gyro = gyro;
    r.other = other;
    req_queue.push_back(r);
    reqs_queued++;
  endtask

  task automatic add_random_requests(input int count);
    int          roll;
    logic [1:0]  kind;
    logic signed [15:0] accel;
    logic signed [15:0] gyro;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) kind = tae_pkg::REQ_SAMPLE;
      else if (roll < 78) kind = tae_pkg::REQ_EDGE_A;
      else if (roll < 96) kind = tae_pkg::REQ_EDGE_B;
      else kind = REQ_RESERVED;

      case ($urandom_range(0, 9))
        0, 1:    accel = 16'($urandom);
        8:       accel = 16'($urandom_range(0, 80) - 40);
        9:       accel = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                             + $urandom_range(0, 6) - 3);
        default: accel = 16'($urandom_range(0, 32768) - 16384);
      endcase

      // mostly a slow walk so the deadband sees both sides of its edge
      case ($urandom_range(0, 9))
        0, 1, 2: gyro_walk = 16'($urandom);
        8, 9:    ;
        default: gyro_walk = 16'(gyro_walk + $urandom_range(0, 600) - 300);
      endcase
      gyro = gyro_walk;

      add_request(kind, accel, gyro, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic configure(input logic [15:0] step_gain, input logic [19:0] enc_gain,
                           input logic [15:0] deadband, input bit with_stray_index);
    logic [19:0] vals [4];
    int          last;
    // upper bits of the narrow registers carry noise that must be dropped
    vals[0] = {4'($urandom), step_gain};
    vals[1] = enc_gain;
    vals[2] = {4'($urandom), deadband};
    vals[3] = 20'($urandom);
    last = with_stray_index ? 3 : 2;
    for (int i = 0; i <= last; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (2'(i))
        tae_pkg::CFG_GYRO_STEP_GAIN: gyro_step_gain = vals[i][15:0];
        tae_pkg::CFG_ENCODER_GAIN:   encoder_gain   = vals[i];
        tae_pkg::CFG_RATE_DEADBAND:  rate_deadband  = vals[i][15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint exp_val, input longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_request(on_bus);
        reqs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.req;
          in_tdata  <= {7'd0, on_bus.other, on_bus.gyro, on_bus.accel};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with a long hold-off now and then to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_angles.size() == 0) begin
        $error("result with no request pending: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_angles.pop_front();
        check_field("encoder_angle", want.encoder_angle, $signed(out_tdata[31:0]));
        check_field("accel_angle", want.accel_angle, $signed(out_tdata[47:32]));
        check_field("gyro_angle", want.gyro_angle, $signed(out_tdata[79:48]));
        check_field("gyro_rate", want.gyro_rate, $signed(out_tdata[96:80]));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    longint unsigned lim;

    // arcsine table, rounded to the nearest 1/256 degree
    for (int i = 0; i <= ASIN_ENTRIES; i++) begin
      lo = 0;
      hi = tae_pkg::QUARTER_TURN;
      lim = longint'(i) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (sine_q30(64'(2 * mid - 1)) * ASIN_ENTRIES <= lim) lo = mid;
        else hi = mid - 1;
      end
      asin_table[i] = (i == ASIN_ENTRIES) ? 16'(tae_pkg::QUARTER_TURN) : 16'(lo);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // calibration: extremes plus a negative sum that truncates toward zero
    add_request(tae_pkg::REQ_SAMPLE, 16'sh7fff, 16'sh7fff, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sh8000, 16'sh8000, 1'b1);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd0, 16'sh7fff, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd0, 16'sh8000, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd100, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd120, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd90, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd110, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd105, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd500, -16'sd95, 1'b0);
    // level sensor: tilt zero, offset stays open
    add_request(tae_pkg::REQ_SAMPLE, 16'sd0, -16'sd62, 1'b0);
    add_request(tae_pkg::REQ_EDGE_A, 16'sd0, 16'sd0, 1'b0);
    add_request(tae_pkg::REQ_EDGE_A, 16'sd0, 16'sd0, 1'b1);
    add_request(tae_pkg::REQ_EDGE_B, 16'sd0, 16'sd0, 1'b0);
    add_request(tae_pkg::REQ_EDGE_B, 16'sd0, 16'sd0, 1'b1);
    add_request(tae_pkg::REQ_EDGE_A, 16'sd0, 16'sd0, 1'b0);
    add_request(REQ_RESERVED, 16'sh7fff, 16'sh7fff, 1'b1);
    // clamped accel on both sides, full-scale gyro
    add_request(tae_pkg::REQ_SAMPLE, 16'sh7fff, 16'sh7fff, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sh8000, 16'sh8000, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd16384, 16'sh8000, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, -16'sd16384, 16'sd0, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd1, 16'sd60, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, -16'sd8192, 16'sd200, 1'b0);
    // one count inside the deadband, then exactly on its edge
    add_request(tae_pkg::REQ_SAMPLE, 16'sd11585, 16'sd330, 1'b0);
    add_request(tae_pkg::REQ_SAMPLE, 16'sd100, 16'sd331, 1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 9 : (p < 4) ? 57 : 0;
      recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 9 : 0;
      case (p)
        0: configure(16'hffff, 20'hfffff, 16'd0, 1'b0);
        1: configure(16'd0, 20'd0, 16'hffff, 1'b0);
        2: configure(16'($urandom), 20'($urandom), 16'($urandom_range(0, 400)), 1'b1);
        3: configure(tae_pkg::GYRO_STEP_GAIN_RST, tae_pkg::ENCODER_GAIN_RST,
                     tae_pkg::RATE_DEADBAND_RST, 1'b0);
        4: configure(16'($urandom), 20'($urandom), 16'($urandom_range(0, 200)), 1'b0);
        default: configure(16'hffff, 20'($urandom), 16'd1, 1'b1);
      endcase
      add_random_requests(135);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
